// ----- hdl/epso_pkg.sv -----
// Package for the exponential-pitch sine oscillator: field widths, register
// indexes, reset values and the elaboration-time table builders.
// No dependencies; imported by exp_pitch_sine_oscillator_unit and its testbench.
package epso_pkg;

    localparam int PITCH_W      = 16;
    localparam int OFFSET_W     = 14;
    localparam int BASE_W       = 28;
    localparam int BLINK_INC_W  = 31;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_DATA_W   = 31;
    localparam int CFG_INDEX_W  = 2;
    localparam int EXP_W        = 31;   // 2^fraction in Q30, always below 2^31
    localparam int MAG_W        = 15;   // sine magnitude 0..32767
    localparam int PROD_W       = BASE_W + EXP_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_OFFSET    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_INCREMENT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_INCREMENT = 2'd2;

    localparam logic [OFFSET_W-1:0]    RST_PITCH_OFFSET    = 14'd0;
    localparam logic [BASE_W-1:0]      RST_BASE_INCREMENT  = 28'd25479805;
    localparam logic [BLINK_INC_W-1:0] RST_BLINK_INCREMENT = 31'd97391;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Bit-by-bit integer square root.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        int i;
        n    = n_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(fq / 2^bits) in Q30 as a product of successive square roots of two.
    function automatic logic [EXP_W-1:0] exp2_frac_q30(input int unsigned fq,
                                                       input int unsigned bits);
        logic [63:0] root;
        logic [63:0] m;
        int unsigned j;
        root = 64'd2 * ONE_Q30;
        m    = ONE_Q30;
        for (j = 1; j <= bits; j++) begin
            root = isqrt64(root << 30);
            if (((fq >> (bits - j)) & 32'd1) != 32'd0) begin
                m = (m * root + (ONE_Q30 >> 1)) >> 30;
            end
        end
        return m[EXP_W-1:0];
    endfunction

    // Quarter-wave sine entry k of a table with 2^(sb-2) steps per quadrant,
    // from a truncated Taylor series in Q30.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned sb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] v;
        x    = (64'(k) * HALF_PI_Q30) >> (sb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = (unsigned'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

// ----- hdl/exp_pitch_sine_oscillator_unit.sv -----
// Exponential-pitch sine oscillator (direct digital synthesis) with a blink light.
// Depends on epso_pkg for widths, register indexes, reset values and table builders.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_pitch_cv
//   out       output     o_out_valid / i_out_ready   o_sine_sample, o_light_on
//   cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while the output is not stalled, and its result
// is valid once it has passed all four registered stages.
// The four stages are: pitch sum and clamp, exponent table and base multiply,
// phase accumulators, sine table and output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the output holds every stage in place.
// Reset is synchronous and active low; it clears the stage valid bits, both
// accumulators and the configuration registers, which return to their defaults.
module exp_pitch_sine_oscillator_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int EXP_TABLE_BITS  = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [epso_pkg::PITCH_W-1:0]   i_pitch_cv,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [epso_pkg::SAMPLE_W-1:0]  o_sine_sample,
    output logic                                  o_light_on,
    input  logic                                  i_cfg_we,
    input  logic [epso_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [epso_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import epso_pkg::*;

    localparam int EXP_SIZE   = 2 ** EXP_TABLE_BITS;
    localparam int QUARTER    = 2 ** (SINE_TABLE_BITS - 2);
    localparam int SINE_SIZE  = QUARTER + 1;
    localparam int KIDX_W     = SINE_TABLE_BITS - 1;
    // Total right shift is (66 - PHASE_BITS) minus the octave index.
    localparam int SHIFT_TOP  = 66 - PHASE_BITS;

    // Constant tables, evaluated at elaboration.
    logic [EXP_W-1:0] w_exp_tab [EXP_SIZE];
    logic [MAG_W-1:0] w_sine_tab [SINE_SIZE];

    for (genvar g = 0; g < EXP_SIZE; g++) begin : g_exp_tab
        localparam logic [EXP_W-1:0] ENTRY = exp2_frac_q30(g, EXP_TABLE_BITS);
        assign w_exp_tab[g] = ENTRY;
    end

    for (genvar g = 0; g < SINE_SIZE; g++) begin : g_sine_tab
        localparam logic [MAG_W-1:0] ENTRY = quarter_sine(g, SINE_TABLE_BITS);
        assign w_sine_tab[g] = ENTRY;
    end

    // Configuration registers.
    logic signed [OFFSET_W-1:0] r_pitch_offset;
    logic [BASE_W-1:0]          r_base_increment;
    logic [BLINK_INC_W-1:0]     r_blink_increment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_offset    <= RST_PITCH_OFFSET;
            r_base_increment  <= RST_BASE_INCREMENT;
            r_blink_increment <= RST_BLINK_INCREMENT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PITCH_OFFSET:    r_pitch_offset    <= i_cfg_data[OFFSET_W-1:0];
                CFG_BASE_INCREMENT:  r_base_increment  <= i_cfg_data[BASE_W-1:0];
                CFG_BLINK_INCREMENT: r_blink_increment <= i_cfg_data[BLINK_INC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: every stage moves when the output register can take a word.
    logic w_adv;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Stage 1: add the offset to the incoming pitch, clamp to +/-4 V and bias
    // the result to an unsigned value of 0..16384.
    logic signed [PITCH_W:0] w_pitch_sum;
    logic signed [PITCH_W:0] w_pitch_clamped;
    logic signed [PITCH_W:0] w_pitch_biased;
    logic [14:0]             r_s1_pitch_u;

    always_comb begin
        w_pitch_sum = {{(PITCH_W + 1 - OFFSET_W){r_pitch_offset[OFFSET_W-1]}}, r_pitch_offset}
                    + {i_pitch_cv[PITCH_W-1], i_pitch_cv};
        if (w_pitch_sum < -17'sd8192) begin
            w_pitch_clamped = -17'sd8192;
        end else if (w_pitch_sum > 17'sd8192) begin
            w_pitch_clamped = 17'sd8192;
        end else begin
            w_pitch_clamped = w_pitch_sum;
        end
        w_pitch_biased = w_pitch_clamped + 17'sd8192;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pitch_u <= w_pitch_biased[14:0];
        end
    end

    // Stage 2: the top fraction bits pick 2^fraction, which scales the base step.
    // The octave index (0..8) travels along for the shift.
    logic [EXP_TABLE_BITS-1:0] w_exp_idx;
    logic [EXP_W-1:0]          w_exp_mult;
    logic [PROD_W-1:0]         r_s2_prod;
    logic [3:0]                r_s2_octave;

    assign w_exp_idx  = r_s1_pitch_u[10 -: EXP_TABLE_BITS];
    assign w_exp_mult = w_exp_tab[w_exp_idx];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_prod   <= PROD_W'(r_base_increment) * PROD_W'(w_exp_mult);
            r_s2_octave <= r_s1_pitch_u[14:11];
        end
    end

    // Stage 3: the octave becomes a right shift of the product, and both phase
    // accumulators step when a word moves through this stage.
    logic [5:0]            w_shamt;
    logic [PROD_W-1:0]     w_shifted;
    logic [PHASE_BITS-1:0] w_osc_inc;
    logic [PHASE_BITS-1:0] r_osc_phase;
    logic [31:0]           r_blink_phase;

    assign w_shamt   = 6'(SHIFT_TOP) - {2'b00, r_s2_octave};
    assign w_shifted = r_s2_prod >> w_shamt;
    assign w_osc_inc = w_shifted[PHASE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_phase   <= '0;
            r_blink_phase <= '0;
        end else if (w_adv && r_s2_valid) begin
            r_osc_phase   <= r_osc_phase + w_osc_inc;
            r_blink_phase <= r_blink_phase + {1'b0, r_blink_increment};
        end
    end

    // Output stage: the top phase bits address the quarter-wave table. Odd
    // quadrants run the table backwards, the upper half of the cycle negates.
    logic [SINE_TABLE_BITS-1:0] w_sine_idx;
    logic [KIDX_W-1:0]          w_k;
    logic [KIDX_W-1:0]          w_k_sel;
    logic [MAG_W-1:0]           w_mag;
    logic [SAMPLE_W-1:0]        w_sample;
    logic signed [SAMPLE_W-1:0] r_sine_sample;
    logic                       r_light_on;

    always_comb begin
        w_sine_idx = r_osc_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        w_k        = {1'b0, w_sine_idx[SINE_TABLE_BITS-3:0]};
        if (w_sine_idx[SINE_TABLE_BITS-2]) begin
            w_k_sel = KIDX_W'(QUARTER) - w_k;
        end else begin
            w_k_sel = w_k;
        end
        w_mag = w_sine_tab[w_k_sel];
        if (w_sine_idx[SINE_TABLE_BITS-1]) begin
            w_sample = {SAMPLE_W{1'b0}} - {1'b0, w_mag};
        end else begin
            w_sample = {1'b0, w_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_sine_sample <= w_sample;
            r_light_on    <= !r_blink_phase[31];
        end
    end

    assign o_sine_sample = r_sine_sample;
    assign o_light_on    = r_light_on;

    // The oscillator phase only moves when a word passes the accumulator stage.
    a_osc_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_s2_valid) |=> $stable(r_osc_phase))
        else $error("oscillator phase moved without a word");

    // The blink phase steps in lockstep with the oscillator phase.
    a_blink_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_s2_valid) |=> $stable(r_blink_phase))
        else $error("blink phase moved without a word");

    // The symmetric sine table never yields the most negative code.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sine_sample != -16'sd32768))
        else $error("sine sample out of range");

    // A stalled output never loses a word held in the accumulator stage.
    a_stall_holds_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_s3_valid) |=> r_s3_valid)
        else $error("word dropped from accumulator stage during stall");

endmodule

// ----- tb/sv/exp_pitch_sine_oscillator_unit_tb.sv -----
// Testbench for exp_pitch_sine_oscillator_unit: directed and random pitch words checked
// against a cycle-free predictor of the oscillator and the blink light.
// Depends on epso_pkg and the RTL of the unit.
module exp_pitch_sine_oscillator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import epso_pkg::*;

    // Index 3 is not a register. A write there must leave every register unchanged.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    // The pipeline is four stages deep, and the settle wait is longer than the pipeline.
    localparam int SETTLE_CYCLES = 6;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int QUARTER       = 256;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       light;
    } t_osc_word;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [PITCH_W-1:0]   i_pitch_cv;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_sine_sample;
    logic                        o_light_on;
    logic                        i_cfg_we;
    logic [CFG_INDEX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    exp_pitch_sine_oscillator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pitch_cv    (i_pitch_cv),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sine_sample (o_sine_sample),
        .o_light_on    (o_light_on),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor copy of the configuration registers and both accumulators.
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [BASE_W-1:0]          base_inc_reg;
    logic [BLINK_INC_W-1:0]     blink_inc_reg;
    logic [31:0]                osc_phase_q;
    logic [31:0]                blink_phase_q;

    // Roots of two in Q30 (root j is 2^(2^-j)) and the quarter-wave magnitudes.
    logic [63:0]       pow2_root [1:8];
    logic [MAG_W-1:0]  sine_mag [0:QUARTER];

    t_osc_word expected_words [$];
    int        error_count;
    int        in_idle_pct;
    int        out_idle_pct;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor of the square root, found one result bit at a time from the top.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] trial;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // Both tables are built once at time zero. The sine entries come from the odd
    // Taylor terms of sin(x) in Q30, each term truncated, and are then scaled to
    // 32767 full scale with rounding half up.
    task automatic build_tables();
        logic [63:0]    x;
        logic [63:0]    x_sq;
        logic [63:0]    term;
        longint         acc;
        longint         scaled;
        logic [63:0]    root;
        root = 64'd2 * ONE_Q30;
        for (int j = 1; j <= 8; j++) begin
            root = floor_sqrt(root << 30);
            pow2_root[j] = root;
        end
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> 8;
            x_sq = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            scaled = (acc * 32767 + 536870912) >>> 30;
            if (scaled > 32767) begin
                scaled = 32767;
            end
            sine_mag[k] = MAG_W'(scaled);
        end
    endtask

    // 2 raised to frac/256 in Q30: one rounded multiply per set fraction bit.
    function automatic logic [63:0] pow2_fraction(input logic [7:0] frac);
        logic [63:0] m;
        m = ONE_Q30;
        for (int j = 1; j <= 8; j++) begin
            if (frac[8-j]) begin
                m = (m * pow2_root[j] + (ONE_Q30 >> 1)) >> 30;
            end
        end
        return m;
    endfunction

    // Advances both accumulators by one accepted pitch word and returns the
    // sample and the light that the unit must produce for it.
    function automatic t_osc_word advance_oscillator(input logic signed [PITCH_W-1:0] cv);
        int          pitch;
        int          biased;
        int          octave;
        logic [63:0] step;
        logic [9:0]  index;
        logic [8:0]  k;
        t_osc_word   w;
        pitch = offset_reg + cv;
        if (pitch < -8192) begin
            pitch = -8192;
        end
        if (pitch > 8192) begin
            pitch = 8192;
        end
        biased = pitch + 8192;
        octave = (biased >> 11) - 4;
        step   = (64'(base_inc_reg) * pow2_fraction(8'((biased & 2047) >> 3)))
                 >> (30 - octave);
        osc_phase_q = osc_phase_q + step[31:0];

        index = osc_phase_q[31:22];
        k     = {1'b0, index[7:0]};
        if (index[8]) begin
            k = 9'(QUARTER) - k;
        end
        w.sample = index[9] ? -$signed({1'b0, sine_mag[k]}) : $signed({1'b0, sine_mag[k]});

        blink_phase_q = blink_phase_q + 32'(blink_inc_reg);
        w.light = ~blink_phase_q[31];
        return w;
    endfunction

    // Offers one pitch word, idling first at the current sender rate, and
    // records its expected result once the unit takes it. Valid is left high;
    // the next call or drain_words decides whether it drops.
    task automatic send_pitch(input logic signed [PITCH_W-1:0] cv);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_pitch_cv <= cv;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_words.push_back(advance_oscillator(cv));
    endtask

    // Stops offering words and waits until every expected word has come back.
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes one register once the unit is idle and mirrors it in the predictor.
    // Bits above the register width carry random filler that must be ignored.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [30:0] value);
        logic [CFG_DATA_W-1:0] data;
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        data = CFG_DATA_W'($urandom);
        case (index)
            CFG_PITCH_OFFSET: begin
                data[OFFSET_W-1:0] = value[OFFSET_W-1:0];
                offset_reg         = value[OFFSET_W-1:0];
            end
            CFG_BASE_INCREMENT: begin
                data[BASE_W-1:0] = value[BASE_W-1:0];
                base_inc_reg     = value[BASE_W-1:0];
            end
            CFG_BLINK_INCREMENT: begin
                data          = value;
                blink_inc_reg = value;
            end
            default: begin
            end
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly pitches in -10000..10000, around the clamp window, plus the whole field,
    // words near the clamp edges and the extremes.
    function automatic logic signed [PITCH_W-1:0] pick_pitch_cv();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = int'($urandom_range(20000)) - 10000;
        end else if (pick < 80) begin
            v = int'($urandom_range(65535));
        end else if (pick < 92) begin
            v = int'($urandom_range(64)) - 32 + ($urandom_range(1) ? 8192 : -8192)
                - int'(offset_reg);
        end else begin
            case ($urandom_range(2))
                0: v = 32767;
                1: v = -32768;
                default: v = 0;
            endcase
        end
        return PITCH_W'(v);
    endfunction

    function automatic logic [30:0] pick_reg_value(input logic [CFG_INDEX_W-1:0] index);
        case (index)
            CFG_PITCH_OFFSET: begin
                if ($urandom_range(3) == 0) begin
                    return 31'($urandom_range(16383));
                end
                return 31'(int'($urandom_range(12288)) - 6144);
            end
            CFG_BASE_INCREMENT: begin
                if ($urandom_range(1) == 0) begin
                    return 31'($urandom_range(1 << 26));
                end
                return 31'($urandom_range(28'hFFFFFFF));
            end
            default: begin
                if ($urandom_range(1) == 0) begin
                    return 31'($urandom_range(1, 1 << 24));
                end
                return 31'($urandom);
            end
        endcase
    endfunction

    // Directed pitch words under the reset configuration: zero, both field
    // extremes, the clamp points, octave borders and alternating bit patterns.
    task automatic test_pitch_extremes();
        logic signed [PITCH_W-1:0] cvs [13];
        cvs = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd8192, -16'sd8192, 16'sd8191,
                -16'sd8191, 16'sd2047, 16'sd2048, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA};
        foreach (cvs[i]) begin
            send_pitch(cvs[i]);
        end
    endtask

    // Register extremes: offsets beyond the nominal knob range, the largest base
    // at +4 V so the step comes just short of a full cycle, zero increments that freeze
    // both accumulators, and a write to the spare index that must change nothing.
    task automatic test_register_extremes();
        write_reg(CFG_PITCH_OFFSET, 31'(-8192));
        send_pitch(16'sd0);
        send_pitch(-16'sd32768);
        write_reg(CFG_PITCH_OFFSET, 31'd8191);
        write_reg(CFG_BASE_INCREMENT, 31'h0FFFFFFF);
        write_reg(CFG_BLINK_INCREMENT, 31'h7FFFFFFF);
        send_pitch(16'sd1);
        send_pitch(16'sd32767);
        send_pitch(16'sd32767);
        write_reg(CFG_BASE_INCREMENT, 31'd0);
        write_reg(CFG_BLINK_INCREMENT, 31'd0);
        send_pitch(16'sd123);
        send_pitch(-16'sd4000);
        write_reg(CFG_SPARE_INDEX, 31'h7FFFFFFF);
        send_pitch(16'sd0);
        write_reg(CFG_PITCH_OFFSET, 31'd0);
        write_reg(CFG_BASE_INCREMENT, 31'(RST_BASE_INCREMENT));
        write_reg(CFG_BLINK_INCREMENT, 31'(RST_BLINK_INCREMENT));
        send_pitch(16'sd2048);
    endtask

    // Random pitch traffic at the given idle rates. Every few dozen words the
    // unit is drained and one register, spare index included, is rewritten.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int words);
        logic [CFG_INDEX_W-1:0] index;
        in_idle_pct  = sender_pct;
        out_idle_pct = receiver_pct;
        for (int i = 0; i < words; i++) begin
            if (i % 40 == 39) begin
                index = CFG_INDEX_W'($urandom_range(3));
                write_reg(index, pick_reg_value(index));
            end
            send_pitch(pick_pitch_cv());
        end
    endtask

    // Output side: checks each word taken against the oldest expectation, then
    // picks the ready level for the next cycle at the current receiver rate.
    always @(posedge i_clk) begin
        t_osc_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word: sine_sample %0d, light_on %0b",
                       o_sine_sample, o_light_on);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_sine_sample !== want.sample) begin
                    $error("sine_sample: expected %0d, actual %0d", want.sample, o_sine_sample);
                    error_count++;
                end
                if (o_light_on !== want.light) begin
                    $error("light_on: expected %0b, actual %0b", want.light, o_light_on);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        quiet_cycles  = 0;
        in_idle_pct   = 16;
        out_idle_pct  = 71;
        offset_reg    = RST_PITCH_OFFSET;
        base_inc_reg  = RST_BASE_INCREMENT;
        blink_inc_reg = RST_BLINK_INCREMENT;
        osc_phase_q   = 32'd0;
        blink_phase_q = 32'd0;
        build_tables();

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pitch_cv  <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PITCH_OFFSET;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pitch_extremes();
        test_register_extremes();
        test_random_traffic(16, 71, 217);
        test_random_traffic(71, 16, 217);
        test_random_traffic(0, 0, 216);

        drain_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/epso_pkg.sv
hdl/exp_pitch_sine_oscillator_unit.sv
tb/sv/exp_pitch_sine_oscillator_unit_tb.sv
